[sv/assert_macros.svh]
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, quiet during reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[sv/sqts_pkg.sv]
// Package with widths, codes and types of the queued SPI transmit sequencer.
package sqts_pkg;

   // Field widths
   localparam int ACTION_W   = 3;
   localparam int RAM_IDX_W  = 4;
   localparam int WORD_W     = 16;
   localparam int STATUS_W   = 8;
   localparam int LEVEL_W    = 3;
   localparam int VECTOR_W   = 8;
   localparam int PTR_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam int DEFAULT_QUEUE_DEPTH = 16;

   typedef logic [ACTION_W-1:0]   action_type;
   typedef logic [RAM_IDX_W-1:0]  ram_idx_type;
   typedef logic [WORD_W-1:0]     word_type;
   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic [LEVEL_W-1:0]    level_type;
   typedef logic [VECTOR_W-1:0]   vector_type;
   typedef logic [PTR_W-1:0]      ptr_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // Action codes
   localparam action_type ACT_TICK       = 3'd0;
   localparam action_type ACT_WR_ENABLE  = 3'd1;
   localparam action_type ACT_WR_HALT    = 3'd2;
   localparam action_type ACT_WR_STATUS  = 3'd3;
   localparam action_type ACT_WR_RAM     = 3'd4;

   // Configuration register indexes
   localparam csr_idx_type CSR_MASTER_MODE  = 3'd0;
   localparam csr_idx_type CSR_BAUD_DIVIDER = 3'd1;
   localparam csr_idx_type CSR_NEW_PTR      = 3'd2;
   localparam csr_idx_type CSR_END_PTR      = 3'd3;
   localparam csr_idx_type CSR_IRQ_ENABLE   = 3'd4;
   localparam csr_idx_type CSR_WRAP_MODE    = 3'd5;
   localparam csr_idx_type CSR_IRQ_LEVEL    = 3'd6;
   localparam csr_idx_type CSR_IRQ_VECTOR   = 3'd7;

   // Wrap modes
   localparam logic [1:0] WRAP_NONE = 2'd0;
   localparam logic [1:0] WRAP_ZERO = 2'd1;

   // Register bits
   localparam int ENABLE_BIT = 15;
   localparam int HALT_BIT   = 8;
   localparam status_type STAT_FINISHED = 8'h80;
   localparam status_type STAT_HALT_ACK = 8'h20;

   // Reset values
   localparam logic [3:0] BAUD_RESET       = 4'd4;
   localparam level_type  IRQ_LEVEL_RESET  = 3'd1;
   localparam vector_type IRQ_VECTOR_RESET = 8'd15;

endpackage

[sv/sqts_req_if.sv]
// Request channel interface of the queued SPI transmit sequencer.
interface sqts_req_if;
   import sqts_pkg::*;

   logic        valid;
   logic        ready;
   action_type  action;
   ram_idx_type ram_index;
   word_type    write_value;

   modport source (output valid, output action, output ram_index, output write_value,
                   input ready);
   modport sink   (input valid, input action, input ram_index, input write_value,
                   output ready);
endinterface

[sv/sqts_rsp_if.sv]
// Response channel interface of the queued SPI transmit sequencer.
interface sqts_rsp_if;
   import sqts_pkg::*;

   logic       valid;
   logic       ready;
   logic       tx_valid;
   word_type   tx_word;
   status_type status_byte;
   logic       enable_bit;
   logic       transfer_active;
   logic       irq_valid;
   vector_type irq_vector_out;
   level_type  irq_level_out;

   modport source (output valid, output tx_valid, output tx_word, output status_byte,
                   output enable_bit, output transfer_active, output irq_valid,
                   output irq_vector_out, output irq_level_out, input ready);
   modport sink   (input valid, input tx_valid, input tx_word, input status_byte,
                   input enable_bit, input transfer_active, input irq_valid,
                   input irq_vector_out, input irq_level_out, output ready);
endinterface

[sv/spi_queue_transmit_sequencer.sv]
// Top level of the queued SPI transmit sequencer.
// A request beat yields its response beat in the cycle after acceptance.
// Throughput: one beat per cycle while rsp ready stays high; a new beat enters in the
// cycle its predecessor's response is taken, and input stalls while a response waits.
// Reset (synchronous): clears state and the transmit RAM and empties the output register.
module spi_queue_transmit_sequencer #(
   parameter int QUEUE_DEPTH = sqts_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   sqts_req_if.sink               req_chan,
   sqts_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  sqts_pkg::csr_idx_type  csr_index,
   input  sqts_pkg::csr_data_type csr_wdata
);
   import sqts_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam ptr_type DEPTH_PTR = PTR_W'(QUEUE_DEPTH);

   // Configuration registers
   logic       master_ff;
   logic [3:0] baud_ff;
   logic [3:0] new_ptr_ff;
   logic [3:0] end_ptr_ff;
   logic       irq_en_ff;
   logic [1:0] wrap_ff;
   level_type  irq_lvl_ff;
   vector_type irq_vec_ff;

   // Sequencer state
   logic       active_ff,  active_in;
   ptr_type    qptr_ff,    qptr_in;
   ptr_type    delay_ff,   delay_in;
   logic       enable_ff,  enable_in;
   logic       halt_ff,    halt_in;
   status_type status_ff,  status_in;
   word_type   ram_ff [QUEUE_DEPTH];

   // Result of the current beat
   logic       tx_valid_in;
   word_type   tx_word_in;
   logic       irq_valid_in;
   vector_type irq_vec_in;
   level_type  irq_lvl_in;

   // Output register
   logic       rsp_valid_ff;
   logic       tx_valid_ff;
   word_type   tx_word_ff;
   status_type status_out_ff;
   logic       enable_out_ff;
   logic       active_out_ff;
   logic       irq_valid_ff;
   vector_type irq_vec_ff_out;
   level_type  irq_lvl_ff_out;

   logic       take;
   logic       ram_we;
   word_type   ram_rd;
   ptr_type    qptr_inc;
   logic       finish;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take = req_chan.valid && req_chan.ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff  <= 1'b0;
         baud_ff    <= BAUD_RESET;
         new_ptr_ff <= '0;
         end_ptr_ff <= '0;
         irq_en_ff  <= 1'b0;
         wrap_ff    <= WRAP_NONE;
         irq_lvl_ff <= IRQ_LEVEL_RESET;
         irq_vec_ff <= IRQ_VECTOR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MASTER_MODE:  master_ff  <= csr_wdata[0];
            CSR_BAUD_DIVIDER: baud_ff    <= csr_wdata[3:0];
            CSR_NEW_PTR:      new_ptr_ff <= csr_wdata[3:0];
            CSR_END_PTR:      end_ptr_ff <= csr_wdata[3:0];
            CSR_IRQ_ENABLE:   irq_en_ff  <= csr_wdata[0];
            CSR_WRAP_MODE:    wrap_ff    <= csr_wdata[1:0];
            CSR_IRQ_LEVEL:    irq_lvl_ff <= csr_wdata[2:0];
            CSR_IRQ_VECTOR:   irq_vec_ff <= csr_wdata;
            default:          master_ff  <= master_ff;
         endcase
      end
   end

   // Read the entry at the queue pointer; past the RAM it reads zero
   assign ram_rd   = (qptr_ff < DEPTH_PTR) ? ram_ff[qptr_ff[IDX_W-1:0]] : '0;
   assign qptr_inc = qptr_ff + PTR_W'(1);
   assign finish   = (qptr_inc > {1'b0, end_ptr_ff}) || (qptr_inc >= DEPTH_PTR);
   assign ram_we   = take && (req_chan.action == ACT_WR_RAM) &&
                     ({1'b0, req_chan.ram_index} < DEPTH_PTR);

   // Next state and result of one beat
   always_comb begin
      active_in    = active_ff;
      qptr_in      = qptr_ff;
      delay_in     = delay_ff;
      enable_in    = enable_ff;
      halt_in      = halt_ff;
      status_in    = status_ff;
      tx_valid_in  = 1'b0;
      tx_word_in   = '0;
      irq_valid_in = 1'b0;
      irq_vec_in   = '0;
      irq_lvl_in   = '0;
      unique case (req_chan.action)
         ACT_TICK: begin
            if (active_ff) begin
               if (delay_ff != '0) begin
                  delay_in = delay_ff - PTR_W'(1);
               end else if (!halt_ff) begin
                  // Send one word and advance
                  delay_in    = {baud_ff, 1'b0};
                  tx_valid_in = 1'b1;
                  tx_word_in  = ram_rd;
                  status_in   = {status_ff[7:4], qptr_ff[3:0]};
                  qptr_in     = qptr_inc;
                  if (finish) begin
                     active_in = 1'b0;
                     status_in = status_in | STAT_FINISHED;
                     if (wrap_ff == WRAP_NONE) begin
                        enable_in = 1'b0;
                     end
                     if (irq_en_ff) begin
                        irq_valid_in = 1'b1;
                        irq_vec_in   = irq_vec_ff | VECTOR_W'(1);
                        irq_lvl_in   = irq_lvl_ff;
                     end
                     // Restart when wrapping
                     if (wrap_ff != WRAP_NONE && master_ff && !halt_ff) begin
                        qptr_in   = (wrap_ff == WRAP_ZERO) ? '0 : {1'b0, new_ptr_ff};
                        active_in = 1'b1;
                     end
                  end
               end
            end
         end
         ACT_WR_ENABLE: begin
            active_in = 1'b0;
            status_in = status_ff | STAT_FINISHED;
            enable_in = 1'b0;
            // Start on a rising enable bit
            if (!enable_ff && req_chan.write_value[ENABLE_BIT] && master_ff && !halt_ff) begin
               qptr_in   = {1'b0, new_ptr_ff};
               active_in = 1'b1;
            end
         end
         ACT_WR_HALT: begin
            halt_in   = req_chan.write_value[HALT_BIT];
            active_in = 1'b0;
            enable_in = 1'b0;
            status_in = status_ff | STAT_FINISHED;
            if (!halt_ff && req_chan.write_value[HALT_BIT]) begin
               status_in = status_in | STAT_HALT_ACK;
            end
         end
         ACT_WR_STATUS: begin
            status_in = req_chan.write_value[STATUS_W-1:0];
         end
         default: begin
            active_in = active_ff;
         end
      endcase
   end

   // Hold state, advance on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         qptr_ff   <= '0;
         delay_ff  <= '0;
         enable_ff <= 1'b0;
         halt_ff   <= 1'b0;
         status_ff <= STAT_FINISHED;
      end else if (take) begin
         active_ff <= active_in;
         qptr_ff   <= qptr_in;
         delay_ff  <= delay_in;
         enable_ff <= enable_in;
         halt_ff   <= halt_in;
         status_ff <= status_in;
      end
   end

   // Transmit RAM, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            ram_ff[i] <= '0;
         end
      end else if (ram_we) begin
         ram_ff[req_chan.ram_index[IDX_W-1:0]] <= req_chan.write_value;
      end
   end

   // Output register: load when empty or drained
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         rsp_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tx_valid_ff    <= tx_valid_in;
         tx_word_ff     <= tx_word_in;
         status_out_ff  <= status_in;
         enable_out_ff  <= enable_in;
         active_out_ff  <= active_in;
         irq_valid_ff   <= irq_valid_in;
         irq_vec_ff_out <= irq_vec_in;
         irq_lvl_ff_out <= irq_lvl_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.tx_valid        = tx_valid_ff;
   assign rsp_chan.tx_word         = tx_word_ff;
   assign rsp_chan.status_byte     = status_out_ff;
   assign rsp_chan.enable_bit      = enable_out_ff;
   assign rsp_chan.transfer_active = active_out_ff;
   assign rsp_chan.irq_valid       = irq_valid_ff;
   assign rsp_chan.irq_vector_out  = irq_vec_ff_out;
   assign rsp_chan.irq_level_out   = irq_lvl_ff_out;

endmodule

[sv/sqts_checker.sv]
// Port checker of the queued SPI transmit sequencer and its bind.
`include "assert_macros.svh"

module sqts_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 tx_valid,
   input sqts_pkg::word_type   tx_word,
   input sqts_pkg::status_type status_byte,
   input logic                 enable_bit,
   input logic                 irq_valid,
   input sqts_pkg::vector_type irq_vector_out,
   input sqts_pkg::level_type  irq_level_out
);
   import sqts_pkg::*;

   // A stalled response beat holds
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(tx_word) && $stable(status_byte) && $stable(enable_bit) && $stable(irq_valid))
   // A finish interrupt comes only with a sent word and the finished flag
   `ASSERT_IMP(a_irq_on_send, clock, reset, rsp_valid && irq_valid, tx_valid && status_byte[7] && irq_vector_out[0])
   // No word shown without a send
   `ASSERT_IMP(a_tx_word_zero, clock, reset, rsp_valid && !tx_valid, tx_word == '0)
   // No vector or level shown without an interrupt
   `ASSERT_IMP(a_irq_fields_zero, clock, reset, rsp_valid && !irq_valid, (irq_vector_out == '0) && (irq_level_out == '0))

endmodule

bind spi_queue_transmit_sequencer sqts_checker u_sqts_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .tx_valid       (rsp_chan.tx_valid),
   .tx_word        (rsp_chan.tx_word),
   .status_byte    (rsp_chan.status_byte),
   .enable_bit     (rsp_chan.enable_bit),
   .irq_valid      (rsp_chan.irq_valid),
   .irq_vector_out (rsp_chan.irq_vector_out),
   .irq_level_out  (rsp_chan.irq_level_out)
);

[verif/sqts_sequencer_checker.sv]
// Checker that predicts and compares the response beats of the queued SPI transmit sequencer.
module sqts_sequencer_checker (
   input  logic                   clock,
   input  logic                   reset,
   sqts_req_if                    req_mon,
   sqts_rsp_if                    rsp_mon,
   input  logic                   csr_we,
   input  sqts_pkg::csr_idx_type  csr_index,
   input  sqts_pkg::csr_data_type csr_wdata,
   output int                     fail_count,
   output int                     outstanding,
   output int                     beats_checked,
   output int                     words_seen,
   output int                     irqs_seen
);
   import sqts_pkg::*;

   localparam int DEPTH = DEFAULT_QUEUE_DEPTH;

   typedef struct packed {
      logic       tx_valid;
      word_type   tx_word;
      status_type status;
      logic       enable_bit;
      logic       active;
      logic       irq_valid;
      vector_type irq_vector;
      level_type  irq_level;
   } report_type;

   // register copy
   logic       master_en;
   logic [3:0] baud;
   logic [3:0] start_ptr;
   logic [3:0] last_ptr;
   logic       irq_en;
   logic [1:0] wrap_sel;
   level_type  irq_level;
   vector_type irq_base;

   // sequencer state copy
   logic       running;
   ptr_type    qptr;
   logic [4:0] wait_ticks;
   word_type   enable_reg;
   word_type   halt_reg;
   status_type status_reg;
   word_type   tx_ram [DEPTH];

   report_type status_reports [$];
   report_type oldest;

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      beats_checked = 0;
      words_seen    = 0;
      irqs_seen     = 0;
   end

   // Stop any transfer and flag it finished
   function automatic void cancel_queue();
      running = 1'b0;
      status_reg = status_reg | STAT_FINISHED;
      enable_reg[ENABLE_BIT] = 1'b0;
   endfunction

   // Load the queue pointer and go active, unless slave or halted
   function automatic void restart_queue(logic at_zero);
      if (master_en && !halt_reg[HALT_BIT]) begin
         qptr = at_zero ? '0 : {1'b0, start_ptr};
         running = 1'b1;
      end
   endfunction

   // Apply one request beat and work out the response it yields
   function automatic report_type step_sequencer(action_type act, ram_idx_type idx,
                                                 word_type val);
      report_type r;
      word_type   prev;
      r = '0;
      case (act)
         ACT_TICK: begin
            if (running) begin
               if (wait_ticks != 0) begin
                  wait_ticks = wait_ticks - 5'd1;
               end else if (!halt_reg[HALT_BIT]) begin
                  wait_ticks = {baud, 1'b0};
                  r.tx_valid = 1'b1;
                  r.tx_word = (qptr < DEPTH) ? tx_ram[qptr[3:0]] : '0;
                  status_reg[3:0] = qptr[3:0];
                  qptr = qptr + 5'd1;
                  // past the end pointer or the end of the RAM: finish
                  if (qptr > {1'b0, last_ptr} || qptr >= DEPTH) begin
                     running = 1'b0;
                     status_reg = status_reg | STAT_FINISHED;
                     if (wrap_sel == WRAP_NONE)
                        enable_reg[ENABLE_BIT] = 1'b0;
                     if (irq_en) begin
                        r.irq_valid = 1'b1;
                        r.irq_vector = irq_base | 8'h01;
                        r.irq_level = irq_level;
                     end
                     if (wrap_sel != WRAP_NONE)
                        restart_queue(wrap_sel == WRAP_ZERO);
                  end
               end
            end
         end
         ACT_WR_ENABLE: begin
            prev = enable_reg;
            enable_reg = val;
            cancel_queue();
            if (!prev[ENABLE_BIT] && val[ENABLE_BIT])
               restart_queue(1'b0);
         end
         ACT_WR_HALT: begin
            prev = halt_reg;
            halt_reg = val;
            cancel_queue();
            if (!prev[HALT_BIT] && val[HALT_BIT])
               status_reg = status_reg | STAT_HALT_ACK;
         end
         ACT_WR_STATUS: status_reg = val[7:0];
         ACT_WR_RAM: tx_ram[idx] = val;
         default: ;
      endcase
      r.status = status_reg;
      r.enable_bit = enable_reg[ENABLE_BIT];
      r.active = running;
      return r;
   endfunction

   task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         master_en = 1'b0;
         baud = BAUD_RESET;
         start_ptr = '0;
         last_ptr = '0;
         irq_en = 1'b0;
         wrap_sel = WRAP_NONE;
         irq_level = IRQ_LEVEL_RESET;
         irq_base = IRQ_VECTOR_RESET;
         running = 1'b0;
         qptr = '0;
         wait_ticks = '0;
         enable_reg = 16'h0404;
         halt_reg = '0;
         status_reg = STAT_FINISHED;
         for (int k = 0; k < DEPTH; k++)
            tx_ram[k] = '0;
         status_reports.delete();
      end else begin
         // check the response beat against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (status_reports.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response beat, status %h", $time,
                        rsp_mon.status_byte);
            end else begin
               oldest = status_reports[0];
               status_reports.delete(0);
               compare_field("tx_valid", 16'(oldest.tx_valid), 16'(rsp_mon.tx_valid));
               compare_field("tx_word", oldest.tx_word, rsp_mon.tx_word);
               compare_field("status_byte", 16'(oldest.status), 16'(rsp_mon.status_byte));
               compare_field("enable_bit", 16'(oldest.enable_bit), 16'(rsp_mon.enable_bit));
               compare_field("transfer_active", 16'(oldest.active),
                             16'(rsp_mon.transfer_active));
               compare_field("irq_valid", 16'(oldest.irq_valid), 16'(rsp_mon.irq_valid));
               compare_field("irq_vector_out", 16'(oldest.irq_vector),
                             16'(rsp_mon.irq_vector_out));
               compare_field("irq_level_out", 16'(oldest.irq_level),
                             16'(rsp_mon.irq_level_out));
               beats_checked++;
               if (rsp_mon.tx_valid === 1'b1)
                  words_seen++;
               if (rsp_mon.irq_valid === 1'b1)
                  irqs_seen++;
            end
         end
         // track register writes
         if (csr_we) begin
            case (csr_index)
               CSR_MASTER_MODE:  master_en = csr_wdata[0];
               CSR_BAUD_DIVIDER: baud = csr_wdata[3:0];
               CSR_NEW_PTR:      start_ptr = csr_wdata[3:0];
               CSR_END_PTR:      last_ptr = csr_wdata[3:0];
               CSR_IRQ_ENABLE:   irq_en = csr_wdata[0];
               CSR_WRAP_MODE:    wrap_sel = csr_wdata[1:0];
               CSR_IRQ_LEVEL:    irq_level = csr_wdata[2:0];
               CSR_IRQ_VECTOR:   irq_base = csr_wdata;
               default: ;
            endcase
         end
         // predict the accepted request beat
         if (req_mon.valid && req_mon.ready)
            status_reports.insert(status_reports.size(),
                                  step_sequencer(req_mon.action, req_mon.ram_index,
                                                 req_mon.write_value));
      end
      outstanding = status_reports.size();
   end

endmodule

[verif/spi_queue_transmit_sequencer_tb.sv]
// Testbench top of the queued SPI transmit sequencer: stimulus, idling and verdict.
module spi_queue_transmit_sequencer_tb;
   import sqts_pkg::*;

   localparam action_type ACT_LAST_SPARE = 3'd7;
   localparam int         LONG_HOLD      = 300;
   localparam logic [1:0] WRAP_TO_NEW    = 2'd2;
   localparam logic [1:0] WRAP_ODD       = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   csr_idx_type  csr_index = '0;
   csr_data_type csr_wdata = '0;

   sqts_req_if req_bus();
   sqts_rsp_if rsp_bus();

   int fail_count;
   int outstanding;
   int beats_checked;
   int words_seen;
   int irqs_seen;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int long_stall_token = 0;
   int stall_seen = 0;
   int hold_left = 0;
   int beats_offered = 0;
   int settings_used = 0;

   csr_data_type regs_now [8];

   spi_queue_transmit_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sqts_sequencer_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .beats_checked (beats_checked),
      .words_seen    (words_seen),
      .irqs_seen     (irqs_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: random stalls, plus a long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_stall_token != stall_seen) begin
            stall_seen = long_stall_token;
            hold_left = LONG_HOLD;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Offer one request beat, idling first at random, and hold it until accepted
   task automatic send_beat(action_type act, ram_idx_type idx, word_type val);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.ram_index <= idx;
      req_bus.write_value <= val;
      beats_offered++;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and wait until every predicted beat has come back
   task automatic wait_for_quiet();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write all eight registers while the block is idle
   task automatic program_regs(csr_data_type master, csr_data_type baud, csr_data_type newp,
                               csr_data_type endp, csr_data_type irq, csr_data_type wrap,
                               csr_data_type level, csr_data_type vec);
      regs_now[CSR_MASTER_MODE] = master;
      regs_now[CSR_BAUD_DIVIDER] = baud;
      regs_now[CSR_NEW_PTR] = newp;
      regs_now[CSR_END_PTR] = endp;
      regs_now[CSR_IRQ_ENABLE] = irq;
      regs_now[CSR_WRAP_MODE] = wrap;
      regs_now[CSR_IRQ_LEVEL] = level;
      regs_now[CSR_IRQ_VECTOR] = vec;
      wait_for_quiet();
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= csr_idx_type'(i);
         csr_wdata <= regs_now[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic set_idling(int mode);
      case (mode)
         1: begin sender_idle_pct = 86; receiver_stall_pct = 0; end
         2: begin sender_idle_pct = 0; receiver_stall_pct = 86; end
         3: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
         default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
      endcase
   endtask

   // Load a few RAM words, write halt (mostly clear), start the queue and tick it through
   task automatic run_transfer();
      int       words;
      int       budget;
      word_type v;
      repeat ($urandom_range(4, 1))
         send_beat(ACT_WR_RAM, ram_idx_type'($urandom), word_type'($urandom));
      if ($urandom_range(3) == 0)
         send_beat(ACT_WR_STATUS, ram_idx_type'($urandom), word_type'($urandom));
      v = word_type'($urandom);
      v[HALT_BIT] = ($urandom_range(9) == 0);
      send_beat(ACT_WR_HALT, ram_idx_type'($urandom), v);
      v = word_type'($urandom);
      v[ENABLE_BIT] = ($urandom_range(9) != 0);
      send_beat(ACT_WR_ENABLE, ram_idx_type'($urandom), v);
      words = (regs_now[CSR_END_PTR] >= regs_now[CSR_NEW_PTR]) ?
              regs_now[CSR_END_PTR] - regs_now[CSR_NEW_PTR] + 1 : 1;
      budget = words * (2 * regs_now[CSR_BAUD_DIVIDER] + 1) + $urandom_range(3);
      // cut some transfers short
      if ($urandom_range(5) == 0)
         budget = $urandom_range(budget);
      repeat (budget) begin
         if ($urandom_range(9) == 0)
            send_beat(action_type'($urandom), ram_idx_type'($urandom), word_type'($urandom));
         else
            send_beat(ACT_TICK, ram_idx_type'($urandom), word_type'($urandom));
      end
   endtask

   initial begin
      int   phase_no;
      logic wide;
      int   newp;
      int   endp;

      req_bus.valid = 1'b0;
      req_bus.action = ACT_TICK;
      req_bus.ram_index = '0;
      req_bus.write_value = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: slave mode, so nothing starts
      send_beat(ACT_TICK, 4'h0, 16'h0000);
      for (int a = ACT_WR_RAM + 1; a <= ACT_LAST_SPARE; a++)
         send_beat(action_type'(a), ram_idx_type'($urandom), word_type'($urandom));
      send_beat(ACT_WR_STATUS, 4'hF, 16'hFF00);
      send_beat(ACT_WR_ENABLE, 4'h0, 16'hFFFF);
      send_beat(ACT_WR_HALT, 4'h0, 16'h0100);
      send_beat(ACT_WR_HALT, 4'h0, 16'h0000);
      send_beat(ACT_WR_RAM, 4'hF, 16'hFFFF);
      send_beat(ACT_WR_RAM, 4'hE, 16'hA5A5);
      send_beat(ACT_WR_RAM, 4'h0, 16'h5A5A);

      // Fastest baud, run into the end of the RAM, odd wrap mode restarts at the new pointer
      program_regs(8'd1, 8'd0, 8'd14, 8'd15, 8'd1, {6'd0, WRAP_ODD}, 8'd7, 8'hFE);
      send_beat(ACT_WR_ENABLE, 4'h0, 16'h8000);
      repeat (3) send_beat(ACT_TICK, 4'h0, 16'h0000);
      // halt cancels; enable while halted must not start
      send_beat(ACT_WR_HALT, 4'h0, 16'h0100);
      send_beat(ACT_WR_ENABLE, 4'h0, 16'h8000);
      send_beat(ACT_TICK, 4'h0, 16'h0000);
      send_beat(ACT_WR_HALT, 4'h0, 16'h0000);
      send_beat(ACT_WR_ENABLE, 4'h0, 16'h8000);
      send_beat(ACT_TICK, 4'h0, 16'h0000);

      // End pointer below the new pointer, wrap to entry zero
      program_regs(8'd1, 8'd1, 8'd15, 8'd0, 8'd1, {6'd0, WRAP_ZERO}, 8'd0, 8'h00);
      send_beat(ACT_WR_ENABLE, 4'h0, 16'h8000);
      repeat (5) send_beat(ACT_TICK, 4'h0, 16'h0000);

      // Random settings, mostly well-formed transfers
      phase_no = 0;
      while (beats_offered < 525 || phase_no < 8) begin
         set_idling(phase_no % 4);
         wide = ($urandom_range(7) == 0);
         newp = $urandom_range(15);
         endp = wide ? ((newp + $urandom_range(1) > 15) ? 15 : newp + $urandom_range(1))
                     : $urandom_range(15);
         program_regs(csr_data_type'($urandom_range(9) != 0),
                      wide ? 8'd15 : csr_data_type'($urandom_range(2)),
                      csr_data_type'(newp), csr_data_type'(endp),
                      csr_data_type'($urandom_range(1)),
                      csr_data_type'($urandom_range(WRAP_ODD)),
                      csr_data_type'($urandom_range(7)), csr_data_type'($urandom_range(255)));
         // hold the response side off so the block fills and backs up
         if (phase_no == 0)
            long_stall_token++;
         repeat ($urandom_range(2, 1))
            run_transfer();
         phase_no++;
      end
      if (sender_idle_pct == 0)
         set_idling(2);
      program_regs(8'd0, 8'd15, 8'd0, 8'd15, 8'd0, {6'd0, WRAP_TO_NEW}, 8'd7, 8'hFF);
      send_beat(ACT_WR_ENABLE, 4'h0, 16'h8000);
      send_beat(ACT_TICK, 4'h0, 16'h0000);

      wait_for_quiet();
      $display("Run covered %0d request beats under %0d register settings;", beats_offered,
               settings_used);
      $display("%0d response beats checked, %0d words sent, %0d finish interrupts.",
               beats_checked, words_seen, irqs_seen);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog
   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
